// ----- src/pua_pkg.sv -----
// ----------------------------------------------------------------------------
// pua_pkg: shared types and constants of the polar unwrap address generator
// Field widths, fixed-point constants, pipeline records and the quarter-wave
// sine table entries.
// ----------------------------------------------------------------------------
package pua_pkg;

   localparam int MAX_SIDE   = 4096;
   localparam int SINE_DEPTH = 1024;

   localparam int SIDE_W       = 13;
   localparam int ANGLE_W      = 14;
   localparam int RADIUS_IDX_W = 11;
   localparam int COORD_W      = 12;
   localparam int DEST_ROW_W   = 11;

   localparam int CENTER_W   = $clog2(MAX_SIDE / 2 + 1);
   localparam int ALPHA_W    = $clog2(MAX_SIDE * 4);
   localparam int REM_W      = ALPHA_W + 1;
   localparam int PHASE_W    = 16;
   localparam int SINE_W     = 15;
   localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);

   localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(512);

   // 2*pi in unsigned Q48, split for two narrow multiplies
   localparam logic [50:0] TWO_PI_Q48 = 51'h6487ED5110B46;
   localparam int          PI_LO_W    = 26;
   localparam int          PI_HI_W    = 51 - PI_LO_W;
   localparam logic [PI_HI_W-1:0] TWO_PI_HI = TWO_PI_Q48[50:PI_LO_W];
   localparam logic [PI_LO_W-1:0] TWO_PI_LO = TWO_PI_Q48[PI_LO_W-1:0];

   localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
   localparam int              TAYLOR_TERMS = 12;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

   typedef struct packed {
      logic [CENTER_W-1:0] radius;
      logic [ALPHA_W-1:0]  alpha;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]      angle_index;
      logic [RADIUS_IDX_W-1:0] radius_index;
      logic                    in_range;
   } tag_type;

   typedef struct packed {
      logic [COORD_W-1:0]    source_row;
      logic [COORD_W-1:0]    source_col;
      logic [DEST_ROW_W-1:0] dest_row;
      logic [ANGLE_W-1:0]    dest_col;
      logic                  in_range;
   } result_type;

   // sin(k*pi/(2*SINE_DEPTH)) in unsigned Q0.15, Taylor series in Q30
   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      x    = (longint'(k) * HALF_PI_Q30) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         if (n[0] == 1'b0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      return SINE_W'(r);
   endfunction

endpackage

// ----- src/pua_channels.sv -----
// ----------------------------------------------------------------------------
// pua_channels: valid/ready channels of the polar unwrap address generator
// Request channel carries pixel indices, response channel carries addresses.
// ----------------------------------------------------------------------------
interface pua_req_if;
   import pua_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ANGLE_W-1:0]      angle_index;
   logic [RADIUS_IDX_W-1:0] radius_index;

   modport source (output valid, output angle_index, output radius_index, input ready);
   modport sink   (input valid, input angle_index, input radius_index, output ready);
endinterface

interface pua_rsp_if;
   import pua_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_W-1:0]    source_row;
   logic [COORD_W-1:0]    source_col;
   logic [DEST_ROW_W-1:0] dest_row;
   logic [ANGLE_W-1:0]    dest_col;
   logic                  in_range;

   modport source (output valid, output source_row, output source_col, output dest_row,
                   output dest_col, output in_range, input ready);
   modport sink   (input valid, input source_row, input source_col, input dest_row,
                   input dest_col, input in_range, output ready);
endinterface

// ----- src/pua_config.sv -----
// ----------------------------------------------------------------------------
// pua_config: image side register and derived geometry
// Holds the side, derives radius and angle count (radius * 2*pi) over two
// register stages after each write.
// ----------------------------------------------------------------------------
module pua_config (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [pua_pkg::SIDE_W-1:0]    csr_write_data,
   output pua_pkg::cfg_type              cfg
);
   import pua_pkg::*;

   localparam int HI_W  = CENTER_W + PI_HI_W;
   localparam int LO_W  = CENTER_W + PI_LO_W;
   localparam int SUM_W = 64;

   localparam int unsigned RESET_SAT = (int'(RESET_SIDE) > MAX_SIDE) ? MAX_SIDE
                                                                     : int'(RESET_SIDE);
   localparam logic [CENTER_W-1:0] RESET_RADIUS = CENTER_W'(RESET_SAT >> 1);
   localparam logic [HI_W-1:0] RESET_HI = HI_W'(RESET_RADIUS) * HI_W'(TWO_PI_HI);
   localparam logic [LO_W-1:0] RESET_LO = LO_W'(RESET_RADIUS) * LO_W'(TWO_PI_LO);
   localparam logic [SUM_W-1:0] RESET_SUM = (SUM_W'(RESET_HI) << PI_LO_W) + SUM_W'(RESET_LO);
   localparam logic [ALPHA_W-1:0] RESET_ALPHA = RESET_SUM[48 +: ALPHA_W];

   logic [SIDE_W-1:0]   side_ff, side_in;
   logic [CENTER_W-1:0] radius_ff, radius_in;
   logic [HI_W-1:0]     prod_hi_ff, prod_hi_in;
   logic [LO_W-1:0]     prod_lo_ff, prod_lo_in;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [31:0]         sat_side;
   logic [SUM_W-1:0]    sum;

   always_comb begin
      side_in    = csr_write_enable ? csr_write_data : side_ff;
      sat_side   = (32'(side_ff) > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : 32'(side_ff);
      radius_in  = CENTER_W'(sat_side >> 1);
      prod_hi_in = HI_W'(radius_in) * HI_W'(TWO_PI_HI);
      prod_lo_in = LO_W'(radius_in) * LO_W'(TWO_PI_LO);
      sum        = (SUM_W'(prod_hi_ff) << PI_LO_W) + SUM_W'(prod_lo_ff);
      alpha_in   = sum[48 +: ALPHA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= RESET_SIDE;
         radius_ff  <= RESET_RADIUS;
         prod_hi_ff <= RESET_HI;
         prod_lo_ff <= RESET_LO;
         alpha_ff   <= RESET_ALPHA;
      end else begin
         side_ff    <= side_in;
         radius_ff  <= radius_in;
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
         alpha_ff   <= alpha_in;
      end
   end

   assign cfg.radius = radius_ff;
   assign cfg.alpha  = alpha_ff;

endmodule

// ----- src/pua_divider.sv -----
// ----------------------------------------------------------------------------
// pua_divider: pipelined restoring divider for the angle phase
// One quotient bit per stage: phase = (angle_index << 16) / angle_count.
// ----------------------------------------------------------------------------
module pua_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  pua_pkg::tag_type              in_tag,
   input  logic [pua_pkg::REM_W-1:0]     in_rem,
   input  logic [pua_pkg::ALPHA_W-1:0]   divisor,
   output logic                          out_valid,
   output pua_pkg::tag_type              out_tag,
   output logic [pua_pkg::PHASE_W-1:0]   out_quotient
);
   import pua_pkg::*;

   localparam int STAGES = PHASE_W;

   logic                valid_ff [STAGES];
   tag_type             tag_ff   [STAGES];
   logic [REM_W-1:0]    rem_ff   [STAGES];
   logic [PHASE_W-1:0]  quot_ff  [STAGES];
   logic [REM_W-1:0]    rem_in   [STAGES];
   logic [PHASE_W-1:0]  quot_in  [STAGES];

   always_comb begin
      logic [REM_W-1:0]   src_rem;
      logic [PHASE_W-1:0] src_quot;
      logic [REM_W-1:0]   shifted;
      logic               take;
      for (int s = 0; s < STAGES; s++) begin
         src_rem    = (s == 0) ? in_rem : rem_ff[(s == 0) ? 0 : s - 1];
         src_quot   = (s == 0) ? '0 : quot_ff[(s == 0) ? 0 : s - 1];
         shifted    = {src_rem[REM_W-2:0], 1'b0};
         take       = (shifted >= REM_W'(divisor));
         rem_in[s]  = take ? (shifted - REM_W'(divisor)) : shifted;
         quot_in[s] = {src_quot[PHASE_W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         for (int s = 0; s < STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
         end
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_tag      = tag_ff[STAGES-1];
   assign out_quotient = quot_ff[STAGES-1];

endmodule

// ----- src/pua_sine_rom.sv -----
// ----------------------------------------------------------------------------
// pua_sine_rom: quarter-wave sine table, two registered read ports
// Entries are unsigned Q0.15 magnitudes of sin(k*pi/(2*depth)), k = 0 .. depth.
// ----------------------------------------------------------------------------
module pua_sine_rom (
   input  logic                              clock,
   input  logic                              read_enable,
   input  logic [pua_pkg::SINE_IDX_W-1:0]    addr_a,
   input  logic [pua_pkg::SINE_IDX_W-1:0]    addr_b,
   output logic [pua_pkg::SINE_W-1:0]        data_a,
   output logic [pua_pkg::SINE_W-1:0]        data_b
);
   import pua_pkg::*;

   logic [SINE_W-1:0] rom_w [SINE_DEPTH+1];

   for (genvar k = 0; k <= SINE_DEPTH; k++) begin : g_entry
      assign rom_w[k] = sine_entry(k);
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         data_a <= rom_w[addr_a];
         data_b <= rom_w[addr_b];
      end
   end

endmodule

// ----- src/polar_unwrap_address_gen.sv -----
// ----------------------------------------------------------------------------
// polar_unwrap_address_gen: source address generator for polar image unwrap
// Maps one polar output pixel to the square source pixel it copies.
//
// req_bus: one transaction per polar pixel (angle_index, radius_index).
// rsp_bus: one transaction per request, in order (source_row, source_col,
//   dest_row, dest_col, in_range).
// csr_write_*: image side register, written while no transaction is in flight;
//   radius settles in the register behind side, angle count behind the products.
// Throughput: one transaction per cycle while the skid buffer is empty. Stages:
//   input, radius check, angle check, the 16-stage phase divider, table
//   address, sine table read, multiply, then the output register.
// Reset: pipeline and output empty, image side 512.
// Stall: the output register plus a one-entry skid buffer absorb the item in
//   flight; the pipeline freezes only when the skid buffer is full, and
//   req_bus.ready follows it. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module polar_unwrap_address_gen (
   input  logic                          clock,
   input  logic                          reset,
   pua_req_if.sink                       req_bus,
   pua_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [pua_pkg::SIDE_W-1:0]    csr_write_data
);
   import pua_pkg::*;

   localparam int IDX_PROD_W = 14 + SINE_IDX_W;
   localparam int MUL_W      = RADIUS_IDX_W + SINE_W;
   localparam int CALC_W     = CENTER_W + 1;

   cfg_type cfg;
   logic    advance;

   // stage 1: input
   logic                    v1_ff;
   logic [ANGLE_W-1:0]      i1_ff;
   logic [RADIUS_IDX_W-1:0] j1_ff;
   // stage 2: radius check
   logic                    v2_ff;
   logic [ANGLE_W-1:0]      i2_ff;
   logic [RADIUS_IDX_W-1:0] j2_ff;
   logic                    jok2_ff, jok2_in;
   // stage 3: angle check, divider seed
   logic                    v3_ff;
   tag_type                 tag3_ff, tag3_in;
   logic [REM_W-1:0]        rem3_ff, rem3_in;
   // divider output
   logic                    vd;
   tag_type                 tagd;
   logic [PHASE_W-1:0]      phase;
   // stage A: table addresses
   logic                    va_ff;
   tag_type                 taga_ff;
   logic [SINE_IDX_W-1:0]   addr_s_ff, addr_s_in, addr_c_ff, addr_c_in;
   logic                    neg_sa_ff, neg_ca_ff;
   logic [IDX_PROD_W-1:0]   idx_prod;
   logic [SINE_IDX_W-1:0]   idx, idx_comp;
   // stage R: table data
   logic                    vr_ff;
   tag_type                 tagr_ff;
   logic                    neg_sr_ff, neg_cr_ff;
   logic [SINE_W-1:0]       sin_mag, cos_mag;
   // stage M: products
   logic                    vm_ff;
   tag_type                 tagm_ff;
   logic                    neg_sm_ff, neg_cm_ff;
   logic [RADIUS_IDX_W-1:0] prod_s_ff, prod_s_in, prod_c_ff, prod_c_in;
   logic [MUL_W-1:0]        mul_s, mul_c;
   // output register and skid buffer
   result_type              result;
   logic [CALC_W-1:0]       row_calc, col_calc;
   logic                    out_valid_ff, out_valid_in;
   result_type              out_ff, out_in;
   logic                    skid_valid_ff, skid_valid_in;
   result_type              skid_ff, skid_in;
   logic                    push, take;

   pua_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign advance       = !skid_valid_ff;
   assign req_bus.ready = advance;

   always_comb begin
      jok2_in              = (32'(j1_ff) < 32'(cfg.radius));
      tag3_in.angle_index  = i2_ff;
      tag3_in.radius_index = j2_ff;
      tag3_in.in_range     = jok2_ff && (32'(i2_ff) < 32'(cfg.alpha));
      rem3_in              = tag3_in.in_range ? REM_W'(i2_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         va_ff <= 1'b0;
         vr_ff <= 1'b0;
         vm_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         va_ff <= vd;
         vr_ff <= va_ff;
         vm_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         i1_ff     <= req_bus.angle_index;
         j1_ff     <= req_bus.radius_index;
         i2_ff     <= i1_ff;
         j2_ff     <= j1_ff;
         jok2_ff   <= jok2_in;
         tag3_ff   <= tag3_in;
         rem3_ff   <= rem3_in;
         taga_ff   <= tagd;
         addr_s_ff <= addr_s_in;
         addr_c_ff <= addr_c_in;
         neg_sa_ff <= phase[PHASE_W-1];
         neg_ca_ff <= phase[PHASE_W-1] ^ phase[PHASE_W-2];
         tagr_ff   <= taga_ff;
         neg_sr_ff <= neg_sa_ff;
         neg_cr_ff <= neg_ca_ff;
         tagm_ff   <= tagr_ff;
         neg_sm_ff <= neg_sr_ff;
         neg_cm_ff <= neg_cr_ff;
         prod_s_ff <= prod_s_in;
         prod_c_ff <= prod_c_in;
      end
   end

   pua_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (v3_ff),
      .in_tag       (tag3_ff),
      .in_rem       (rem3_ff),
      .divisor      (cfg.alpha),
      .out_valid    (vd),
      .out_tag      (tagd),
      .out_quotient (phase)
   );

   // quadrant in phase[15:14]; odd quadrants read the sine mirrored, even ones the cosine
   always_comb begin
      idx_prod  = IDX_PROD_W'(phase[13:0]) * IDX_PROD_W'(SINE_DEPTH);
      idx       = idx_prod[14 +: SINE_IDX_W];
      idx_comp  = SINE_IDX_W'(SINE_DEPTH) - idx;
      addr_s_in = phase[PHASE_W-2] ? idx_comp : idx;
      addr_c_in = phase[PHASE_W-2] ? idx : idx_comp;
   end

   pua_sine_rom u_sine_rom (
      .clock       (clock),
      .read_enable (advance),
      .addr_a      (addr_s_ff),
      .addr_b      (addr_c_ff),
      .data_a      (sin_mag),
      .data_b      (cos_mag)
   );

   always_comb begin
      mul_s     = MUL_W'(tagr_ff.radius_index) * MUL_W'(sin_mag);
      mul_c     = MUL_W'(tagr_ff.radius_index) * MUL_W'(cos_mag);
      prod_s_in = mul_s[SINE_W +: RADIUS_IDX_W];
      prod_c_in = mul_c[SINE_W +: RADIUS_IDX_W];
   end

   always_comb begin
      row_calc = neg_sm_ff ? (CALC_W'(cfg.radius) - CALC_W'(prod_s_ff))
                           : (CALC_W'(cfg.radius) + CALC_W'(prod_s_ff));
      col_calc = neg_cm_ff ? (CALC_W'(cfg.radius) - CALC_W'(prod_c_ff))
                           : (CALC_W'(cfg.radius) + CALC_W'(prod_c_ff));
      result.in_range   = tagm_ff.in_range;
      result.dest_col   = tagm_ff.angle_index;
      if (tagm_ff.in_range) begin
         result.source_row = COORD_W'(row_calc);
         result.source_col = COORD_W'(col_calc);
         result.dest_row   = DEST_ROW_W'(CALC_W'(cfg.radius) - CALC_W'(1)
                                         - CALC_W'(tagm_ff.radius_index));
      end else begin
         result.source_row = '0;
         result.source_col = '0;
         result.dest_row   = '0;
      end
   end

   // output register with one-entry skid buffer
   always_comb begin
      push          = advance && vm_ff;
      take          = out_valid_ff && rsp_bus.ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.source_row = out_ff.source_row;
   assign rsp_bus.source_col = out_ff.source_col;
   assign rsp_bus.dest_row   = out_ff.dest_row;
   assign rsp_bus.dest_col   = out_ff.dest_col;
   assign rsp_bus.in_range   = out_ff.in_range;

endmodule
